// ----- rtl/i2c_master_bit_sequencer_defines.svh -----
// Assertion macros used by the I2C bit sequencer RTL.
`ifndef I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled while in reset
`define I2CMS_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("i2cms assertion failed");

// next-cycle implication, disabled while in reset
`define I2CMS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("i2cms assertion failed");

`else

`define I2CMS_ASSERT_IMPL(label, clk, rst_n, lhs, rhs)
`define I2CMS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)

`endif

`endif

// ----- rtl/i2cms_pkg.sv -----
// Types and constants of the I2C master bit sequencer.
`default_nettype none

package i2cms_pkg;

	// configuration port
	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 32;
	localparam logic CFG_TICKS_PER_US = 1'b0;
	localparam logic CFG_ACK_TIMEOUT  = 1'b1;
	localparam logic [7:0] TICKS_PER_US_RST = 8'd1;
	localparam logic [7:0] ACK_TIMEOUT_RST  = 8'd250;

	// wait lengths as shifts of one microsecond
	localparam logic [1:0] WAIT_1US = 2'd0;
	localparam logic [1:0] WAIT_2US = 2'd1;
	localparam logic [1:0] WAIT_4US = 2'd2;

	// command codes
	typedef enum logic [2:0] {
		OP_START = 3'd0,
		OP_STOP  = 3'd1,
		OP_SEND  = 3'd2,
		OP_RECV  = 3'd3,
		OP_SACK  = 3'd4,
		OP_WACK  = 3'd5
	} op_t;

	// sequence phases
	typedef enum logic [4:0] {
		PH_IDLE  = 5'd0,
		PH_STA_A = 5'd1,
		PH_STA_B = 5'd2,
		PH_STO_A = 5'd3,
		PH_STO_B = 5'd4,
		PH_ACK_A = 5'd5,
		PH_ACK_B = 5'd6,
		PH_WT_A  = 5'd7,
		PH_WT_B  = 5'd8,
		PH_POLL  = 5'd9,
		PH_TX_A  = 5'd10,
		PH_TX_B  = 5'd11,
		PH_TX_C  = 5'd12,
		PH_RX_A  = 5'd13,
		PH_RX_B  = 5'd14
	} phase_t;

	// register settings seen by the sequencer
	typedef struct packed {
		logic [7:0] ticks_per_us;
		logic [7:0] ack_timeout;
	} cfg_t;

endpackage

`default_nettype wire

// ----- rtl/i2c_master_bit_sequencer.sv -----
// Top level of the I2C master bit sequencer: tick-driven SCL/SDA sequencing.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  tick in | in        | in_valid / in_ready  | cmd_valid opcode tx_byte ack_value sda_in
//  result  | out       | out_valid / out_ready| scl_out sda_out busy_res done_res
//          |           |                      | rx_byte ack_failed
//  config  | in        | APB, pready tied 1   | ticks_per_us at 0x0, ack_timeout at 0x4
//
// One tick transfer is taken per clock cycle while in_ready is high; its result is shown on the next cycle.
// The sequencer state registers themselves form the result register, updated on
// every accepted tick by one pass of next-state logic.
// A new tick is taken while a result waits, provided out_ready takes it that cycle.
// Reset releases both lines, clears the sequencer and loads the register defaults.
`default_nettype none
`include "i2c_master_bit_sequencer_defines.svh"

module i2c_master_bit_sequencer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// tick channel
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          cmd_valid,
	input  wire logic [2:0]                    opcode,
	input  wire logic [7:0]                    tx_byte,
	input  wire logic                          ack_value,
	input  wire logic                          sda_in,
	// result channel
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               scl_out,
	output logic                               sda_out,
	output logic                               busy_res,
	output logic                               done_res,
	output logic      [7:0]                    rx_byte,
	output logic                               ack_failed,
	// configuration
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [i2cms_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [i2cms_pkg::DATA_W-1:0]  pwdata,
	output logic      [i2cms_pkg::DATA_W-1:0]  prdata,
	output logic                               pready
);

	i2cms_pkg::cfg_t   cfg;

	i2cms_pkg::phase_t phase_q, phase_n;
	i2cms_pkg::op_t    kind_q, kind_n;
	logic [2:0]        bit_q, bit_n;
	logic [9:0]        dly_q, dly_n;
	logic [7:0]        poll_q, poll_n;
	logic [7:0]        shift_q, shift_n;
	logic              scl_q, scl_n;
	logic              sda_q, sda_n;
	logic              ack_q, ack_n;
	logic [7:0]        rx_q, rx_n;
	logic              done_q, done_n;
	logic              out_valid_q;
	logic              in_fire;
	logic              do_poll;
	logic              in_poll;
	logic              poll_ok;
	logic              rx_end_tick;

	i2cms_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// delay in ticks for 1, 2 or 4 microseconds; a rate of zero counts as one
	function automatic logic [9:0] wait_ticks(input logic [1:0] sh, input logic [7:0] tpu);
		logic [7:0] t;
		t = (tpu == 8'd0) ? 8'd1 : tpu;
		return {2'b00, t} << sh;
	endfunction

	assign in_ready = ~out_valid_q | out_ready;
	assign in_fire  = in_valid & in_ready;
	assign in_poll  = (phase_q == i2cms_pkg::PH_POLL);

	// next state for one tick
	always_comb begin
		phase_n = phase_q;
		kind_n  = kind_q;
		bit_n   = bit_q;
		dly_n   = dly_q;
		poll_n  = poll_q;
		shift_n = shift_q;
		scl_n   = scl_q;
		sda_n   = sda_q;
		ack_n   = ack_q;
		rx_n    = rx_q;
		done_n  = 1'b0;
		do_poll = 1'b0;

		if (phase_q == i2cms_pkg::PH_IDLE) begin
			// command launch
			if (cmd_valid && opcode <= i2cms_pkg::OP_WACK) begin
				kind_n = i2cms_pkg::op_t'(opcode);
				bit_n  = 3'd0;
				poll_n = 8'd0;
				case (opcode)
					i2cms_pkg::OP_START: begin
						sda_n   = 1'b1;
						scl_n   = 1'b1;
						dly_n   = wait_ticks(i2cms_pkg::WAIT_4US, cfg.ticks_per_us);
						phase_n = i2cms_pkg::PH_STA_A;
					end
					i2cms_pkg::OP_STOP: begin
						scl_n   = 1'b0;
						sda_n   = 1'b0;
						dly_n   = wait_ticks(i2cms_pkg::WAIT_4US, cfg.ticks_per_us);
						phase_n = i2cms_pkg::PH_STO_A;
					end
					i2cms_pkg::OP_SEND: begin
						scl_n   = 1'b0;
						sda_n   = tx_byte[7];
						shift_n = {tx_byte[6:0], 1'b0};
						dly_n   = wait_ticks(i2cms_pkg::WAIT_2US, cfg.ticks_per_us);
						phase_n = i2cms_pkg::PH_TX_A;
					end
					i2cms_pkg::OP_RECV: begin
						sda_n   = 1'b1;
						shift_n = 8'd0;
						scl_n   = 1'b0;
						dly_n   = wait_ticks(i2cms_pkg::WAIT_2US, cfg.ticks_per_us);
						phase_n = i2cms_pkg::PH_RX_A;
					end
					i2cms_pkg::OP_SACK: begin
						scl_n   = 1'b0;
						sda_n   = ack_value;
						dly_n   = wait_ticks(i2cms_pkg::WAIT_2US, cfg.ticks_per_us);
						phase_n = i2cms_pkg::PH_ACK_A;
					end
					default: begin
						sda_n   = 1'b1;
						dly_n   = wait_ticks(i2cms_pkg::WAIT_1US, cfg.ticks_per_us);
						phase_n = i2cms_pkg::PH_WT_A;
					end
				endcase
			end
		end else if (in_poll) begin
			do_poll = 1'b1;
		end else if (dly_q > 10'd1) begin
			dly_n = dly_q - 10'd1;
		end else begin
			// wait over: perform the writes that follow it
			dly_n = 10'd0;
			case (phase_q)
				i2cms_pkg::PH_STA_A: begin
					sda_n   = 1'b0;
					dly_n   = wait_ticks(i2cms_pkg::WAIT_4US, cfg.ticks_per_us);
					phase_n = i2cms_pkg::PH_STA_B;
				end
				i2cms_pkg::PH_STA_B: begin
					scl_n   = 1'b0;
					phase_n = i2cms_pkg::PH_IDLE;
					done_n  = 1'b1;
				end
				i2cms_pkg::PH_STO_A: begin
					scl_n   = 1'b1;
					sda_n   = 1'b1;
					dly_n   = wait_ticks(i2cms_pkg::WAIT_4US, cfg.ticks_per_us);
					phase_n = i2cms_pkg::PH_STO_B;
				end
				i2cms_pkg::PH_STO_B: begin
					if (kind_q == i2cms_pkg::OP_WACK) begin
						ack_n = 1'b1;
					end
					phase_n = i2cms_pkg::PH_IDLE;
					done_n  = 1'b1;
				end
				i2cms_pkg::PH_ACK_A: begin
					scl_n   = 1'b1;
					dly_n   = wait_ticks(i2cms_pkg::WAIT_2US, cfg.ticks_per_us);
					phase_n = i2cms_pkg::PH_ACK_B;
				end
				i2cms_pkg::PH_ACK_B: begin
					scl_n   = 1'b0;
					phase_n = i2cms_pkg::PH_IDLE;
					done_n  = 1'b1;
				end
				i2cms_pkg::PH_WT_A: begin
					scl_n   = 1'b1;
					dly_n   = wait_ticks(i2cms_pkg::WAIT_1US, cfg.ticks_per_us);
					phase_n = i2cms_pkg::PH_WT_B;
				end
				i2cms_pkg::PH_WT_B: begin
					do_poll = 1'b1;
				end
				i2cms_pkg::PH_TX_A: begin
					scl_n   = 1'b1;
					dly_n   = wait_ticks(i2cms_pkg::WAIT_2US, cfg.ticks_per_us);
					phase_n = i2cms_pkg::PH_TX_B;
				end
				i2cms_pkg::PH_TX_B: begin
					scl_n   = 1'b0;
					dly_n   = wait_ticks(i2cms_pkg::WAIT_2US, cfg.ticks_per_us);
					phase_n = i2cms_pkg::PH_TX_C;
				end
				i2cms_pkg::PH_TX_C: begin
					if (bit_q == 3'd7) begin
						phase_n = i2cms_pkg::PH_IDLE;
						done_n  = 1'b1;
					end else begin
						bit_n   = bit_q + 3'd1;
						sda_n   = shift_q[7];
						shift_n = {shift_q[6:0], 1'b0};
						dly_n   = wait_ticks(i2cms_pkg::WAIT_2US, cfg.ticks_per_us);
						phase_n = i2cms_pkg::PH_TX_A;
					end
				end
				i2cms_pkg::PH_RX_A: begin
					scl_n   = 1'b1;
					shift_n = {shift_q[6:0], sda_in};
					dly_n   = wait_ticks(i2cms_pkg::WAIT_1US, cfg.ticks_per_us);
					phase_n = i2cms_pkg::PH_RX_B;
				end
				i2cms_pkg::PH_RX_B: begin
					if (bit_q == 3'd7) begin
						rx_n    = shift_q;
						phase_n = i2cms_pkg::PH_IDLE;
						done_n  = 1'b1;
					end else begin
						bit_n   = bit_q + 3'd1;
						scl_n   = 1'b0;
						dly_n   = wait_ticks(i2cms_pkg::WAIT_2US, cfg.ticks_per_us);
						phase_n = i2cms_pkg::PH_RX_A;
					end
				end
				default: begin
					phase_n = i2cms_pkg::PH_IDLE;
				end
			endcase
		end

		// acknowledge poll: low ends the command, too many highs run the stop waits
		if (do_poll) begin
			if (!sda_in) begin
				scl_n   = 1'b0;
				ack_n   = 1'b0;
				phase_n = i2cms_pkg::PH_IDLE;
				done_n  = 1'b1;
			end else if (poll_q >= cfg.ack_timeout) begin
				scl_n   = 1'b0;
				sda_n   = 1'b0;
				dly_n   = wait_ticks(i2cms_pkg::WAIT_4US, cfg.ticks_per_us);
				phase_n = i2cms_pkg::PH_STO_A;
			end else begin
				poll_n  = poll_q + 8'd1;
				phase_n = i2cms_pkg::PH_POLL;
			end
		end
	end

	// sequencer state, which doubles as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= i2cms_pkg::PH_IDLE;
			kind_q  <= i2cms_pkg::OP_START;
			bit_q   <= 3'd0;
			dly_q   <= 10'd0;
			poll_q  <= 8'd0;
			shift_q <= 8'd0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			ack_q   <= 1'b0;
			rx_q    <= 8'd0;
			done_q  <= 1'b0;
		end else if (in_fire) begin
			phase_q <= phase_n;
			kind_q  <= kind_n;
			bit_q   <= bit_n;
			dly_q   <= dly_n;
			poll_q  <= poll_n;
			shift_q <= shift_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			ack_q   <= ack_n;
			rx_q    <= rx_n;
			done_q  <= done_n;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign scl_out    = scl_q;
	assign sda_out    = sda_q;
	assign busy_res   = (phase_q != i2cms_pkg::PH_IDLE);
	assign done_res   = done_q;
	assign rx_byte    = rx_q;
	assign ack_failed = ack_q;

	// poll phase belongs to wait ack with its delay spent; received byte lands at RX_B
	assign poll_ok     = (kind_q == i2cms_pkg::OP_WACK) && (dly_q == 10'd0);
	assign rx_end_tick = in_fire && (phase_q == i2cms_pkg::PH_RX_B);

	// checks
	`I2CMS_ASSERT_IMPL(a_done_not_busy, clk, arst_n, out_valid && done_res, !busy_res)
	`I2CMS_ASSERT_NEXT(a_fire_gives_result, clk, arst_n, in_fire, out_valid)
	`I2CMS_ASSERT_IMPL(a_poll_only_wack, clk, arst_n, in_poll, poll_ok)
	`I2CMS_ASSERT_NEXT(a_rx_held, clk, arst_n, !rx_end_tick, $stable(rx_q))

endmodule

`default_nettype wire

// ----- rtl/i2cms_cfg.sv -----
// APB register block holding the bus timing settings.
`default_nettype none

module i2cms_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [i2cms_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [i2cms_pkg::DATA_W-1:0]  pwdata,
	output logic      [i2cms_pkg::DATA_W-1:0]  prdata,
	output logic                               pready,
	output i2cms_pkg::cfg_t                    cfg
);

	logic       wr_en;
	logic [7:0] ticks_q;
	logic [7:0] timeout_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// register writes on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q   <= i2cms_pkg::TICKS_PER_US_RST;
			timeout_q <= i2cms_pkg::ACK_TIMEOUT_RST;
		end else if (wr_en) begin
			case (paddr[2])
				i2cms_pkg::CFG_TICKS_PER_US: ticks_q   <= pwdata[7:0];
				i2cms_pkg::CFG_ACK_TIMEOUT:  timeout_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (paddr[2])
			i2cms_pkg::CFG_TICKS_PER_US: prdata = {24'd0, ticks_q};
			i2cms_pkg::CFG_ACK_TIMEOUT:  prdata = {24'd0, timeout_q};
			default:                     prdata = '0;
		endcase
	end

	assign cfg.ticks_per_us = ticks_q;
	assign cfg.ack_timeout  = timeout_q;

endmodule

`default_nettype wire
